// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the list normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only when out of reset.
`define LMN_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked only when out of reset.
`define LMN_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/lmn_pkg.sv -----
// ----------------------------------------------------------------------------
// lmn_pkg
// Types and constants shared by the list min-max normalizer modules.
// ----------------------------------------------------------------------------
package lmn_pkg;

    // Item value width and the fixed-point format of the result.
    localparam int VAL_W       = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUOT_W      = FRAC_BITS + 1;
    localparam int STEP_W      = $clog2(QUOT_W);
    localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(1) << FRAC_BITS;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;      // accepted request: store item and update min/max
        logic idx_clr;    // restart the emission index
        logic rd_en;      // read buffer entry at the emission index
        logic take_item;  // load the output register from the buffer entry
        logic div_start;  // start the divider on the buffer entry
        logic take_quot;  // load the divider quotient into the output value
        logic idx_inc;    // step to the next buffer entry
        logic list_clr;   // drop the list state after the final result
    } lmn_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;   // buffer entry is a number and the span is nonzero
        logic div_done;   // divider quotient is ready
        logic last_idx;   // emission index points at the final stored item
    } lmn_sts_t;

endpackage

// ----- hw/rtl/lmn_ram.sv -----
// ----------------------------------------------------------------------------
// lmn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmn_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/lmn_div.sv -----
// ----------------------------------------------------------------------------
// lmn_div
// Restoring divider for floor((d << 16) / span) with d <= span.
// ----------------------------------------------------------------------------
module lmn_div
    import lmn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [VAL_W-1:0]  dividend,
    input  logic [VAL_W-1:0]  divisor,
    output logic              done,
    output logic [QUOT_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic              first_reg;
    logic [STEP_W-1:0] step_reg;
    logic [VAL_W:0]    rem_reg;
    logic [VAL_W-1:0]  den_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [VAL_W:0]    rem_shift;
    logic              fits;

    // The first step compares the plain dividend; later steps shift in a zero.
    // The remainder stays below the divisor, so the shift never overflows.
    always_comb begin
        rem_shift = first_reg ? rem_reg : {rem_reg[VAL_W-1:0], 1'b0};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    // Control: one quotient bit per cycle, done pulses after the last bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(QUOT_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: remainder, divisor and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= {1'b0, dividend};
            den_reg   <= divisor;
            quot_reg  <= '0;
            step_reg  <= '0;
            first_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg   <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            quot_reg  <= {quot_reg[QUOT_W-2:0], fits};
            step_reg  <= step_reg + STEP_W'(1);
            first_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- hw/rtl/lmn_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmn_ctrl
// Controller for the list normalizer: loading, then emission item by item.
// ----------------------------------------------------------------------------
module lmn_ctrl
    import lmn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last_item,
    input  logic     m_ready,
    input  lmn_sts_t sts,
    output logic     s_ready,
    output logic     m_valid,
    output lmn_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_CALC,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD: begin
                cmd.store = s_valid;
                if (s_valid && s_last_item) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_CALC;
            end
            S_CALC: begin
                cmd.take_item = 1'b1;
                if (sts.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.take_quot = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    if (sts.last_idx) begin
                        cmd.list_clr = 1'b1;
                        state_next   = S_LOAD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_LOAD);
    assign m_valid = (state_reg == S_OUT);

endmodule

// ----- hw/rtl/lmn_dp.sv -----
// ----------------------------------------------------------------------------
// lmn_dp
// Datapath: list buffer, running min/max, divider and output register.
// ----------------------------------------------------------------------------
module lmn_dp
    import lmn_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lmn_cmd_t                cmd,
    output lmn_sts_t                sts,
    input  logic signed [VAL_W-1:0] s_item_value,
    input  logic                    s_is_number,
    output logic signed [VAL_W-1:0] m_out_value,
    output logic                    m_out_is_number,
    output logic                    m_out_last,
    output logic                    m_normalized_ok,
    output logic                    m_overflowed
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [CW-1:0]           count_reg;
    logic [AW-1:0]           idx_reg;
    logic signed [VAL_W-1:0] min_reg;
    logic signed [VAL_W-1:0] max_reg;
    logic                    seen_reg;
    logic                    ovf_reg;
    logic [VAL_W-1:0]        out_value_reg;
    logic                    out_flag_reg;
    logic                    out_last_reg;

    logic                    room;
    logic [VAL_W:0]          rd_data;
    logic [VAL_W-1:0]        rd_value;
    logic                    rd_flag;
    logic [VAL_W-1:0]        span;
    logic [VAL_W-1:0]        offset;
    logic                    div_done;
    logic [QUOT_W-1:0]       quot;

    assign room     = count_reg < CW'(LIST_DEPTH);
    assign rd_value = rd_data[VAL_W-1:0];
    assign rd_flag  = rd_data[VAL_W];

    // Span and offset are taken modulo 2^32; both are true values in range.
    assign span   = VAL_W'(max_reg - min_reg);
    assign offset = VAL_W'(signed'(rd_value) - min_reg);

    // List buffer: value with its number flag in one word.
    lmn_ram #(
        .WIDTH (VAL_W + 1),
        .DEPTH (LIST_DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (cmd.store && room),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({s_is_number, s_item_value}),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Divider for the normalized fraction.
    lmn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (offset),
        .divisor  (span),
        .done     (div_done),
        .quotient (quot)
    );

    // List statistics: fill count, running min/max, number and overflow flags.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.list_clr) begin
            count_reg <= '0;
            min_reg   <= {1'b0, {(VAL_W-1){1'b1}}};
            max_reg   <= {1'b1, {(VAL_W-1){1'b0}}};
            seen_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (cmd.store) begin
            if (room) begin
                count_reg <= count_reg + CW'(1);
                if (s_is_number) begin
                    seen_reg <= 1'b1;
                    if (s_item_value < min_reg) begin
                        min_reg <= s_item_value;
                    end
                    if (s_item_value > max_reg) begin
                        max_reg <= s_item_value;
                    end
                end
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Emission index.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // Output register. A number in a list of equal numbers reads as one.
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            out_value_reg <= (rd_flag && seen_reg) ? ONE_Q16 : rd_value;
            out_flag_reg  <= rd_flag;
            out_last_reg  <= sts.last_idx;
        end else if (cmd.take_quot) begin
            out_value_reg <= VAL_W'(quot);
        end
    end

    assign sts.need_div = rd_flag && seen_reg && (span != '0);
    assign sts.div_done = div_done;
    assign sts.last_idx = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign m_out_value     = signed'(out_value_reg);
    assign m_out_is_number = out_flag_reg;
    assign m_out_last      = out_last_reg;
    assign m_normalized_ok = seen_reg;
    assign m_overflowed    = ovf_reg;

endmodule

// ----- hw/rtl/list_minmax_normalizer.sv -----
// ----------------------------------------------------------------------------
// list_minmax_normalizer
// Min-max normalization of a list of Q16.16 numbers into unsigned Q1.16.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while loading a list of up to
// LIST_DEPTH items into its buffer; items beyond that are dropped and flagged
// as overflow. The request marked last starts emission, during which no new
// request is taken. Each stored item is then read from the buffer, loaded into
// the output register and held there until m_ready; a number to scale also
// waits for the divider, which produces one quotient bit per cycle over
// seventeen steps and is shared by all items. Emission reads the buffer RAM
// one entry at a time through its single read port. After the final result is
// taken the block is ready for the next list at once; there is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module list_minmax_normalizer
    import lmn_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_item_value,
    input  logic                    s_is_number,
    input  logic                    s_last_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_out_value,
    output logic                    m_out_is_number,
    output logic                    m_out_last,
    output logic                    m_normalized_ok,
    output logic                    m_overflowed
);

    lmn_cmd_t cmd;
    lmn_sts_t sts;

    // Controller.
    lmn_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_item (s_last_item),
        .m_ready     (m_ready),
        .sts         (sts),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .cmd         (cmd)
    );

    // Datapath.
    lmn_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_item_value    (s_item_value),
        .s_is_number     (s_is_number),
        .m_out_value     (m_out_value),
        .m_out_is_number (m_out_is_number),
        .m_out_last      (m_out_last),
        .m_normalized_ok (m_normalized_ok),
        .m_overflowed    (m_overflowed)
    );

    // Loading and emission never overlap.
    `LMN_ASSERT_IMP(a_no_overlap, aclk, aresetn, s_ready, !m_valid)

    // The last request of a list closes the input side.
    `LMN_ASSERT_NXT(a_last_closes, aclk, aresetn, s_valid && s_ready && s_last_item, !s_ready)

    // A normalized number lies between zero and one.
    `LMN_ASSERT_IMP(a_range, aclk, aresetn, m_valid && m_out_is_number && m_normalized_ok, (m_out_value >= 0) && (m_out_value <= signed'(ONE_Q16)))

    // Taking the final result clears the list status and reopens the input.
    `LMN_ASSERT_NXT(a_list_done, aclk, aresetn, m_valid && m_ready && m_out_last, s_ready && !m_normalized_ok && !m_overflowed)

endmodule

// ----- sim/tb_list_minmax_normalizer.sv -----
// ----------------------------------------------------------------------------
// tb_list_minmax_normalizer
// Self-checking bench for the list min-max normalizer.
// Lists of numbers and payloads go in through the request channel. A
// scoreboard keeps its own copy of the list, the running minimum and maximum
// and the overflow state. On the last request of each list it computes the
// scaled results, and each result the block returns is checked against them.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_list_minmax_normalizer;
    import lmn_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_ITEMS = 160;
    localparam int MAX_REPORTS = 10;

    // One result of the block, in port order.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             is_num;
        logic             last;
        logic             ok;
        logic             ovf;
    } norm_result_t;

    // Scoreboard: holds the list being loaded and the results still to come.
    class norm_board;
        logic [VAL_W-1:0]        held_value[DEPTH];
        bit                      held_num[DEPTH];
        int                      held_count;
        logic signed [VAL_W-1:0] low_mark;
        logic signed [VAL_W-1:0] high_mark;
        bit                      any_number;
        bit                      overflow_seen;
        norm_result_t            scaled_due[$];
        int                      failures;

        function new();
            failures = 0;
            start_list();
        endfunction

        function void start_list();
            held_count = 0;
            low_mark = 32'sh7FFF_FFFF;
            high_mark = 32'sh8000_0000;
            any_number = 0;
            overflow_seen = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%0t: mismatch %0d: %s", $time, failures, msg);
            end
        endfunction

        // Store an accepted request; on the last one, scale the whole list.
        function void note_request(logic [VAL_W-1:0] value, bit num, bit last);
            longint       span;
            longint       delta;
            longint       quot;
            int           i;
            norm_result_t r;
            if (held_count < DEPTH) begin
                held_value[held_count] = value;
                held_num[held_count] = num;
                held_count++;
                if (num) begin
                    if ($signed(value) < low_mark) low_mark = $signed(value);
                    if ($signed(value) > high_mark) high_mark = $signed(value);
                    any_number = 1;
                end
            end else begin
                // No room left: the request is dropped and only flagged.
                overflow_seen = 1;
            end
            if (!last) return;

            span = longint'(high_mark) - longint'(low_mark);
            for (i = 0; i < held_count; i++) begin
                r.value = held_value[i];
                if (held_num[i] && any_number) begin
                    if (span <= 0) begin
                        // All numbers equal: each one maps to 1.0.
                        r.value = ONE_Q16;
                    end else begin
                        delta = longint'($signed(held_value[i])) - longint'(low_mark);
                        quot = (delta <<< FRAC_BITS) / span;
                        r.value = 32'(quot);
                    end
                end
                r.is_num = held_num[i];
                r.last = (i == held_count - 1);
                r.ok = any_number;
                r.ovf = overflow_seen;
                scaled_due.push_back(r);
            end
            start_list();
        endfunction

        // Compare one returned result with the oldest one outstanding.
        function void check_result(norm_result_t got);
            norm_result_t want;
            if (scaled_due.size() == 0) begin
                note_failure($sformatf("result %h with none outstanding", got.value));
                return;
            end
            want = scaled_due.pop_front();
            if (got !== want) begin
                note_failure($sformatf(
                    "value %h/%h number %b/%b last %b/%b ok %b/%b ovf %b/%b (exp/act)",
                    want.value, got.value, want.is_num, got.is_num, want.last,
                    got.last, want.ok, got.ok, want.ovf, got.ovf));
            end
        endfunction

        function int outstanding();
            return scaled_due.size();
        endfunction

        function void close();
            if (scaled_due.size() != 0) begin
                note_failure($sformatf("%0d results never arrived", scaled_due.size()));
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [VAL_W-1:0] s_item_value;
    logic                    s_is_number;
    logic                    s_last_item;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [VAL_W-1:0] m_out_value;
    logic                    m_out_is_number;
    logic                    m_out_last;
    logic                    m_normalized_ok;
    logic                    m_overflowed;

    norm_board board;
    bit        steady;

    list_minmax_normalizer #(
        .LIST_DEPTH(DEPTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item_value   (s_item_value),
        .s_is_number    (s_is_number),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_out_is_number(m_out_is_number),
        .m_out_last     (m_out_last),
        .m_normalized_ok(m_normalized_ok),
        .m_overflowed   (m_overflowed)
    );

    // Clock with a period of 20.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Item values with weight on the extremes and on nearby values.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return 32'($urandom_range(0, 511)) - 32'd256;
            4: return 32'($urandom_range(0, 8)) << FRAC_BITS;
            default: return $urandom();
        endcase
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [VAL_W-1:0] value, input bit num,
                                input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item_value <= value;
        s_is_number <= num;
        s_last_item <= last;
        do @(posedge aclk); while (!s_ready);
        board.note_request(value, num, last);
        @(negedge aclk);
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (board.outstanding() != 0);
    endtask

    // Result monitor, sampled at the rising edge.
    always @(posedge aclk) begin
        norm_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.value = m_out_value;
            got.is_num = m_out_is_number;
            got.last = m_out_last;
            got.ok = m_normalized_ok;
            got.ovf = m_overflowed;
            board.check_result(got);
        end
    end

    // Result side back-pressure: runs of ready, with short and rare long stalls.
    initial begin : ready_driver
        int run;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            if (steady || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                run = $urandom_range(1, 16);
            end else begin
                m_ready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            end
            repeat (run) @(negedge aclk);
        end
    end

    // Main sequence.
    initial begin : stimulus
        int               sent;
        int               list_no;
        int               len;
        int               kind;
        int               k;
        bit               num;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] v;

        board = new();
        steady = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item_value <= '0;
        s_is_number <= 1'b0;
        s_last_item <= 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A single number is a list whose numbers are all equal.
        send_request(32'h1234_5678, 1, 1);

        // Extremes of the value range mixed with payloads; widest span.
        send_request(32'h8000_0000, 1, 0);
        send_request(32'h7FFF_FFFF, 1, 0);
        send_request(32'hFFFF_FFFF, 0, 0);
        send_request(32'h0000_0000, 1, 0);
        send_request(32'hFFFF_FFFF, 1, 0);
        send_request(32'h0000_0000, 0, 0);
        send_request(32'h0001_0000, 1, 1);

        // A list with no numbers passes through and reports failure.
        send_request(32'h7FFF_FFFF, 0, 0);
        send_request(32'h8000_0000, 0, 0);
        send_request(32'h5A5A_A5A5, 0, 1);

        // Equal numbers with a payload in between.
        send_request(32'hFFFE_8000, 1, 0);
        send_request(32'h0000_ABCD, 0, 0);
        send_request(32'hFFFE_8000, 1, 0);
        send_request(32'hFFFE_8000, 1, 1);

        // Smallest nonzero span at the top of the range.
        send_request(32'h7FFF_FFFE, 1, 0);
        send_request(32'h7FFF_FFFF, 1, 1);

        wait_drained();

        // Random lists: one that overflows, one exactly full, then mostly short.
        sent = 0;
        list_no = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            if (list_no == 0) begin
                len = DEPTH + 4;
            end else if (list_no == 1) begin
                len = DEPTH;
            end else if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(11, DEPTH + 3);
            end else begin
                len = $urandom_range(1, 10);
            end
            kind = $urandom_range(0, 9);
            base = pick_value();
            for (k = 0; k < len; k++) begin
                case (kind)
                    // Payloads only.
                    0: begin
                        num = 0;
                        v = $urandom();
                    end
                    // Equal numbers among payloads.
                    1: begin
                        num = ($urandom_range(0, 3) != 0);
                        v = num ? base : $urandom();
                    end
                    // Numbers clustered close together.
                    2: begin
                        num = ($urandom_range(0, 4) != 0);
                        v = base + 32'($urandom_range(0, 63));
                    end
                    default: begin
                        num = ($urandom_range(0, 3) != 0);
                        v = pick_value();
                    end
                endcase
                send_request(v, num, k == len - 1);
            end
            sent += len;
            if ($urandom_range(0, 3) == 0) wait_drained();
            list_no++;
        end

        steady = 0;
        wait_drained();
        repeat (40) @(negedge aclk);
        board.close();
        if (board.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lmn_pkg.sv
hw/rtl/lmn_ram.sv
hw/rtl/lmn_div.sv
hw/rtl/lmn_ctrl.sv
hw/rtl/lmn_dp.sv
hw/rtl/list_minmax_normalizer.sv
sim/tb_list_minmax_normalizer.sv
